// ----- rtl/aepb_pkg.sv -----
package aepb_pkg;

  localparam int PEDAL_W = 13;
  localparam int DECEL_W = 15;
  localparam int ERR_W = DECEL_W + 1;
  localparam int DT_W = 16;
  localparam int GAIN_W = 16;
  localparam int FBD_W = 14;
  localparam int Q_SHIFT = 12;
  localparam int P_SHIFT = 8;
  localparam int DVD_W = DECEL_W - 1 + Q_SHIFT;
  localparam int CHUNK_W = 24;
  localparam int MUL_A_W = CHUNK_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int INTEG_WIDTH_DEF = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PEDAL_W-1:0] PEDAL_ONE = 13'd4096;
  localparam logic [FBD_W-1:0] FBD_RST = 14'd2560;
  localparam logic [GAIN_W-1:0] KP_RST = 16'd4096;
  localparam logic [GAIN_W-1:0] KI_RST = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_BRAKE = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [FBD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/aepb_if.sv -----
interface aepb_in_if import aepb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      emerg_request;
  logic                      kickdown_on;
  logic [PEDAL_W-1:0]        throttle_pedal;
  logic [PEDAL_W-1:0]        brake_pedal;
  logic signed [DECEL_W-1:0] demanded_decel;
  logic signed [DECEL_W-1:0] measured_decel;
  logic [DT_W-1:0]           frame_time;

  modport source(output valid, emerg_request, kickdown_on, throttle_pedal, brake_pedal,
                 demanded_decel, measured_decel, frame_time, input ready);
  modport sink(input valid, emerg_request, kickdown_on, throttle_pedal, brake_pedal,
               demanded_decel, measured_decel, frame_time, output ready);
endinterface

interface aepb_out_if import aepb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PEDAL_W-1:0] throttle_cmd;
  logic [PEDAL_W-1:0] brake_cmd;
  logic [PEDAL_W-1:0] safety_brake_cmd;
  logic               engaged;
  logic               suppressed;
  logic               driver_dominant;

  modport source(output valid, throttle_cmd, brake_cmd, safety_brake_cmd, engaged, suppressed,
                 driver_dominant, input ready);
  modport sink(input valid, throttle_cmd, brake_cmd, safety_brake_cmd, engaged, suppressed,
               driver_dominant, output ready);
endinterface

interface aepb_cfg_if import aepb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/aepb_div.sv -----
module aepb_div import aepb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [FBD_W-1:0] rem_q;
  logic [FBD_W-1:0] dsr_q;
  logic [DVD_W-1:0] quo_q;
  logic [FBD_W:0]   trial;
  logic [FBD_W:0]   diff;
  logic             take;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign take  = trial >= {1'b0, dsr_q};

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
      end else if (busy_q) begin
        rem_q <= take ? diff[FBD_W-1:0] : trial[FBD_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], take};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divide started while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divide done held");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divide done while busy");

endmodule

// ----- rtl/aepb_mul.sv -----
module aepb_mul import aepb_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/aeb_pedal_arbiter_pi_brake.sv -----
// Emergency-braking pedal arbiter with a PI brake loop.
// Channels: in_ch takes one control frame per beat, out_ch returns one result
// beat per frame, cfg_ch writes full_brake_decel (0), prop_gain (1) and
// integ_gain (2); other indexes are dropped. cfg_ch is always ready; it is to be
// written only while no frame is in flight, which the block does not enforce.
// A frame without an emergency request or with kickdown passes the pedals
// through S_START and S_OUT into the output register. An engaged frame uses
// the one-bit-per-cycle feedforward divider (26 steps) and the single 25x17
// multiplier that forms kp*err, err*dt and one or, when the integrator
// updates, two passes of ki*integral in 24-bit chunks. Without a positive
// demand, or with full_brake_decel zero, the divide is skipped.
// in_ch takes one frame at a time; it is ready again once the result sits in
// the output register, so a stalled out_ch holds at most one result and
// blocks only the frame after next.
// Reset loads the default gains and clears the integrator and both
// handshakes; no clearing pass is needed.
module aeb_pedal_arbiter_pi_brake import aepb_pkg::*; #(
  parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  aepb_in_if.sink    in_ch,
  aepb_out_if.source out_ch,
  aepb_cfg_if.sink   cfg_ch
);

  localparam int NCH = (INTEG_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W = NCH * CHUNK_W;
  localparam int CK_W = $clog2(NCH);
  localparam int RAW_W = (INTEG_WIDTH + 2 > PROD_W) ? INTEG_WIDTH + 2 : PROD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_PMUL, S_PACC, S_IMUL, S_IACC, S_GATE, S_INTEG, S_OUT
  } state_e;

  state_e                        state_q;
  logic [FBD_W-1:0]              fbd_q;
  logic [GAIN_W-1:0]             kp_q;
  logic [GAIN_W-1:0]             ki_q;
  logic                          req_q;
  logic                          kick_q;
  logic [PEDAL_W-1:0]            thr_q;
  logic [PEDAL_W-1:0]            brk_q;
  logic signed [DECEL_W-1:0]     dem_q;
  logic signed [ERR_W-1:0]       err_q;
  logic [DT_W-1:0]               dt_q;
  logic [PEDAL_W-1:0]            ff_q;
  logic signed [RAW_W-1:0]       base_q;
  logic signed [RAW_W-1:0]       acc_q;
  logic signed [RAW_W-1:0]       raw_q;
  logic signed [INTEG_WIDTH-1:0] integ_q;
  logic [CK_W-1:0]               ck_q;
  logic                          pass_q;
  logic                          out_valid_q;
  logic [PEDAL_W-1:0]            out_thr_q;
  logic [PEDAL_W-1:0]            out_brk_q;
  logic [PEDAL_W-1:0]            out_cmd_q;
  logic                          out_eng_q;
  logic                          out_sup_q;
  logic                          out_dom_q;

  logic                          bypass;
  logic                          dem_pos;
  logic                          div_go;
  div_req_t                      div_req;
  div_rsp_t                      div_rsp;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PAD_W-1:0]       integ_pad;
  logic [CHUNK_W-1:0]            chunk;
  logic signed [RAW_W-1:0]       sum;
  logic                          sum_fits;
  logic [INTEG_WIDTH-1:0]        integ_sat;
  logic                          raw_neg;
  logic                          raw_le0;
  logic                          raw_ge1;
  logic                          raw_gt1;
  logic                          err_pos;
  logic                          err_neg;
  logic                          gate;
  logic [PEDAL_W-1:0]            cmd;
  logic                          out_free;

  assign bypass  = !req_q || kick_q;
  assign dem_pos = !dem_q[DECEL_W-1] && (dem_q != '0);
  assign div_go  = (state_q == S_START) && !bypass && dem_pos && (fbd_q != '0);

  assign div_req.start    = div_go;
  assign div_req.dividend = {dem_q[DECEL_W-2:0], {Q_SHIFT{1'b0}}};
  assign div_req.divisor  = fbd_q;

  aepb_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign integ_pad = PAD_W'(integ_q);
  assign chunk     = integ_pad[ck_q*CHUNK_W +: CHUNK_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PMUL: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = {1'b0, kp_q};
      end
      S_IMUL: begin
        mul_a = (ck_q == CK_W'(NCH - 1)) ? {chunk[CHUNK_W-1], chunk} : {1'b0, chunk};
        mul_b = {1'b0, ki_q};
      end
      S_GATE: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = {1'b0, dt_q};
      end
      default: ;
    endcase
  end

  aepb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // saturating integrator update
  assign sum      = RAW_W'(integ_q) + RAW_W'(prod);
  assign sum_fits = (&sum[RAW_W-1:INTEG_WIDTH-1]) || !(|sum[RAW_W-1:INTEG_WIDTH-1]);
  assign integ_sat = sum_fits ? sum[INTEG_WIDTH-1:0] :
                     (sum[RAW_W-1] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                   : {1'b0, {(INTEG_WIDTH-1){1'b1}}});

  assign raw_neg = raw_q[RAW_W-1];
  assign raw_le0 = raw_neg || (raw_q == '0);
  assign raw_ge1 = !raw_neg && (raw_q[RAW_W-2:0] >= (RAW_W-1)'(PEDAL_ONE));
  assign raw_gt1 = !raw_neg && (raw_q[RAW_W-2:0] > (RAW_W-1)'(PEDAL_ONE));
  assign err_neg = err_q[ERR_W-1];
  assign err_pos = !err_neg && (err_q != '0);
  assign gate    = (dt_q != '0) && !(raw_ge1 && err_pos) && !(raw_le0 && err_neg);
  assign cmd     = raw_neg ? '0 : (raw_gt1 ? PEDAL_ONE : raw_q[PEDAL_W-1:0]);
  assign out_free = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbd_q <= FBD_RST;
      kp_q  <= KP_RST;
      ki_q  <= KI_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FULL_BRAKE: fbd_q <= cfg_ch.data[FBD_W-1:0];
        REG_PROP_GAIN:  kp_q  <= cfg_ch.data[GAIN_W-1:0];
        REG_INTEG_GAIN: ki_q  <= cfg_ch.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= 1'b0;
      kick_q      <= 1'b0;
      thr_q       <= '0;
      brk_q       <= '0;
      dem_q       <= '0;
      err_q       <= '0;
      dt_q        <= '0;
      ff_q        <= '0;
      base_q      <= '0;
      acc_q       <= '0;
      raw_q       <= '0;
      integ_q     <= '0;
      ck_q        <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_thr_q   <= '0;
      out_brk_q   <= '0;
      out_cmd_q   <= '0;
      out_eng_q   <= 1'b0;
      out_sup_q   <= 1'b0;
      out_dom_q   <= 1'b0;
    end else begin
      if (out_ch.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_q   <= in_ch.emerg_request;
            kick_q  <= in_ch.kickdown_on;
            thr_q   <= in_ch.throttle_pedal;
            brk_q   <= in_ch.brake_pedal;
            dem_q   <= in_ch.demanded_decel;
            err_q   <= ERR_W'(in_ch.demanded_decel) - ERR_W'(in_ch.measured_decel);
            dt_q    <= in_ch.frame_time;
            state_q <= S_START;
          end
        end
        S_START: begin
          pass_q <= 1'b0;
          if (bypass) begin
            integ_q <= '0;
            state_q <= S_OUT;
          end else if (!dem_pos) begin
            ff_q    <= '0;
            state_q <= S_PMUL;
          end else if (fbd_q == '0) begin
            ff_q    <= PEDAL_ONE;
            state_q <= S_PMUL;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            ff_q <= (div_rsp.quotient > DVD_W'(PEDAL_ONE)) ? PEDAL_ONE
                                                           : div_rsp.quotient[PEDAL_W-1:0];
            state_q <= S_PMUL;
          end
        end
        S_PMUL: begin
          state_q <= S_PACC;
        end
        S_PACC: begin
          base_q  <= RAW_W'(ff_q) + RAW_W'(prod >>> P_SHIFT);
          acc_q   <= '0;
          ck_q    <= CK_W'(NCH - 1);
          state_q <= S_IMUL;
        end
        S_IMUL: begin
          state_q <= S_IACC;
        end
        S_IACC: begin
          // upper chunks by Horner, lowest chunk adds its integer part last
          if (ck_q != '0) begin
            acc_q   <= (acc_q <<< CHUNK_W) + RAW_W'(prod);
            ck_q    <= ck_q - 1'b1;
            state_q <= S_IMUL;
          end else begin
            raw_q   <= base_q + acc_q + RAW_W'(prod >>> CHUNK_W);
            state_q <= pass_q ? S_OUT : S_GATE;
          end
        end
        S_GATE: begin
          state_q <= gate ? S_INTEG : S_OUT;
        end
        S_INTEG: begin
          integ_q <= integ_sat;
          acc_q   <= '0;
          ck_q    <= CK_W'(NCH - 1);
          pass_q  <= 1'b1;
          state_q <= S_IMUL;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (bypass) begin
              out_thr_q <= thr_q;
              out_brk_q <= brk_q;
              out_cmd_q <= '0;
              out_eng_q <= 1'b0;
              out_sup_q <= req_q && kick_q;
              out_dom_q <= 1'b0;
            end else begin
              out_thr_q <= '0;
              out_brk_q <= (brk_q > cmd) ? brk_q : cmd;
              out_cmd_q <= cmd;
              out_eng_q <= 1'b1;
              out_sup_q <= 1'b0;
              out_dom_q <= brk_q >= cmd;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid            = out_valid_q;
  assign out_ch.throttle_cmd     = out_thr_q;
  assign out_ch.brake_cmd        = out_brk_q;
  assign out_ch.safety_brake_cmd = out_cmd_q;
  assign out_ch.engaged          = out_eng_q;
  assign out_ch.suppressed       = out_sup_q;
  assign out_ch.driver_dominant  = out_dom_q;

  a_engaged_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.engaged |-> out_ch.throttle_cmd == '0 && !out_ch.suppressed)
    else $error("engaged beat with throttle or suppressed set");
  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.safety_brake_cmd <= PEDAL_ONE &&
                     out_ch.brake_cmd >= out_ch.safety_brake_cmd)
    else $error("safety command out of range");
  a_bypass_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START && bypass |=> integ_q == '0)
    else $error("integrator not cleared on pass-through");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divide result outside divide wait");
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second frame taken while busy");

endmodule
